// File: hdl/tdr_pkg.sv
// ----------------------------------------------------------------------------
// tdr_pkg
// Shared types, codes and constants of the tank drive ramp and H-bridge block.
// ----------------------------------------------------------------------------
package tdr_pkg;

  localparam int DUTY_FULL_DEF = 4095;
  localparam int PCT_SCALE     = 100;
  localparam int DUTY_W        = 13;
  localparam int STEP_W        = 7;
  localparam int MOTOR_N       = 4;

  typedef logic signed [7:0]  pct_t;
  typedef logic [DUTY_W-1:0]  duty_t;
  typedef logic [STEP_W-1:0]  step_t;
  typedef logic [1:0]         kind_t;
  typedef logic [1:0]         motor_sel_t;

  localparam kind_t KIND_SET  = 2'd0;
  localparam kind_t KIND_TICK = 2'd1;
  localparam kind_t KIND_STOP = 2'd2;
  localparam kind_t KIND_SOLO = 2'd3;

  localparam pct_t  PCT_MAX       = 8'sd100;
  localparam pct_t  PCT_MIN       = -8'sd100;
  localparam step_t RAMP_STEP_RST = 7'd8;

  typedef struct packed {
    kind_t      kind;
    pct_t       left_target;
    pct_t       right_target;
    motor_sel_t motor_select;
    pct_t       motor_speed;
  } in_word_t;

  // motor order: front left, back left, front right, back right
  typedef struct packed {
    pct_t                   left_level;
    pct_t                   right_level;
    pct_t                   left_goal;
    pct_t                   right_goal;
    logic [MOTOR_N-1:0][7:0] cmd;
  } drive_state_t;

  typedef struct packed {
    logic [MOTOR_N-1:0][DUTY_W-1:0] fwd;
    logic [MOTOR_N-1:0][DUTY_W-1:0] rev;
  } duty_set_t;

endpackage

// File: hdl/tdr_if.sv
// ----------------------------------------------------------------------------
// tdr_if
// Valid/ready channels for command words and pin duty result words.
// ----------------------------------------------------------------------------
interface tdr_in_if
  import tdr_pkg::*;
  ();
  logic       valid;
  logic       ready;
  kind_t      kind;
  pct_t       left_target;
  pct_t       right_target;
  motor_sel_t motor_select;
  pct_t       motor_speed;

  modport source (output valid, kind, left_target, right_target, motor_select,
                  motor_speed, input ready);
  modport sink   (input valid, kind, left_target, right_target, motor_select,
                  motor_speed, output ready);
endinterface

interface tdr_out_if
  import tdr_pkg::*;
  ();
  logic  valid;
  logic  ready;
  duty_t fl_fwd_duty;
  duty_t fl_rev_duty;
  duty_t rl_fwd_duty;
  duty_t rl_rev_duty;
  duty_t fr_fwd_duty;
  duty_t fr_rev_duty;
  duty_t rr_fwd_duty;
  duty_t rr_rev_duty;
  pct_t  left_level_now;
  pct_t  right_level_now;

  modport source (output valid, fl_fwd_duty, fl_rev_duty,
                  rl_fwd_duty, rl_rev_duty, fr_fwd_duty,
                  fr_rev_duty, rr_fwd_duty, rr_rev_duty,
                  left_level_now, right_level_now, input ready);
  modport sink   (input valid, fl_fwd_duty, fl_rev_duty,
                  rl_fwd_duty, rl_rev_duty, fr_fwd_duty,
                  fr_rev_duty, rr_fwd_duty, rr_rev_duty,
                  left_level_now, right_level_now, output ready);
endinterface

// File: hdl/tdr_step.sv
// ----------------------------------------------------------------------------
// tdr_step
// Next drive state for one command word: goals, slew-limited levels, motors.
// ----------------------------------------------------------------------------
module tdr_step
  import tdr_pkg::*;
(
  input  drive_state_t st,
  input  in_word_t     word,
  input  step_t        ramp_step,
  output drive_state_t nxt
);

  function automatic pct_t clamp_pct(input pct_t v);
    pct_t r;
    r = v;
    if ($signed(v) < $signed(PCT_MIN)) r = PCT_MIN;
    else if ($signed(v) > $signed(PCT_MAX)) r = PCT_MAX;
    return r;
  endfunction

  function automatic pct_t approach(input pct_t cur, input pct_t goal, input step_t step);
    logic signed [9:0] c;
    logic signed [9:0] g;
    logic signed [9:0] s;
    logic signed [9:0] n;
    pct_t              r;
    c = {{2{cur[7]}}, cur};
    g = {{2{goal[7]}}, goal};
    s = {3'b000, (step == '0) ? step_t'(1) : step};
    r = cur;
    n = c;
    if (c < g) begin
      n = c + s;
      r = (n > g) ? goal : n[7:0];
    end else if (c > g) begin
      n = c - s;
      r = (n < g) ? goal : n[7:0];
    end
    return r;
  endfunction

  pct_t nl;
  pct_t nr;

  assign nl = approach(st.left_level, st.left_goal, ramp_step);
  assign nr = approach(st.right_level, st.right_goal, ramp_step);

  always_comb begin
    nxt = st;
    case (word.kind)
      KIND_SET: begin
        nxt.left_goal  = clamp_pct(word.left_target);
        nxt.right_goal = clamp_pct(word.right_target);
      end
      KIND_TICK: begin
        if (nl != st.left_level || nr != st.right_level) begin
          nxt.left_level  = nl;
          nxt.right_level = nr;
          nxt.cmd         = {nr, nr, nl, nl};
        end
      end
      KIND_STOP: begin
        nxt = '0;
      end
      KIND_SOLO: begin
        nxt = '0;
        nxt.cmd[word.motor_select] = clamp_pct(word.motor_speed);
      end
      default: begin
        nxt = st;
      end
    endcase
  end

endmodule

// File: hdl/tdr_duty.sv
// ----------------------------------------------------------------------------
// tdr_duty
// Motor percent to H-bridge pin duties through a constant percent table.
// ----------------------------------------------------------------------------
module tdr_duty
  import tdr_pkg::*;
#(
  parameter int DUTY_FULL = DUTY_FULL_DEF
) (
  input  logic [MOTOR_N-1:0][7:0] cmd,
  output duty_set_t               duty
);

  typedef duty_t duty_tab_t [0:PCT_SCALE];

  function automatic duty_tab_t build_tab(input int full);
    duty_tab_t t;
    int        d;
    for (int p = 0; p <= PCT_SCALE; p++) begin
      if (p == 0) d = 0;
      else if (p >= PCT_SCALE) d = full + 1;
      else begin
        d = (p * full) / PCT_SCALE;
        if (d == 0) d = 1;
      end
      t[p] = d[DUTY_W-1:0];
    end
    return t;
  endfunction

  localparam duty_tab_t DUTY_TAB = build_tab(DUTY_FULL);

  logic [MOTOR_N-1:0][7:0] mag;

  always_comb begin
    for (int m = 0; m < MOTOR_N; m++) begin
      mag[m] = cmd[m][7] ? 8'(-$signed(cmd[m])) : cmd[m];
      duty.fwd[m] = '0;
      duty.rev[m] = '0;
      if ($signed(cmd[m]) > 0) duty.fwd[m] = DUTY_TAB[mag[m][6:0]];
      if ($signed(cmd[m]) < 0) duty.rev[m] = DUTY_TAB[mag[m][6:0]];
    end
  end

endmodule

// File: hdl/tank_drive_ramp_hbridge_unit.sv
// ----------------------------------------------------------------------------
// tank_drive_ramp_hbridge_unit
// Tank drive with slew-limited side levels driving four H-bridge motors.
//
//   channel   dir   handshake        word
//   in_ch     in    valid/ready      kind, targets, override motor and speed
//   out_ch    out   valid/ready      eight pin duties, left and right levels
//   cfg_*     in    write enable     ramp_step
//
// One word enters per cycle unless in_ch.ready is low; each word passes through
// the input register and then the result register.
// Synchronous active-low reset clears levels, goals, motors; ramp_step to 8.
// A stalled result holds; one more word waits in the input register, then
// in_ch.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module tank_drive_ramp_hbridge_unit
  import tdr_pkg::*;
#(
  parameter int DUTY_FULL = DUTY_FULL_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_wr_en,
  input  step_t    cfg_wr_data,
  tdr_in_if.sink   in_ch,
  tdr_out_if.source out_ch
);

  step_t        ramp_step_r;
  logic         in_vld_r;
  in_word_t     in_word_r;
  drive_state_t st_r;
  drive_state_t st_nxt;
  duty_set_t    duty_nxt;
  duty_set_t    duty_r;
  pct_t         out_left_r;
  pct_t         out_right_r;
  logic         out_vld_r;
  logic         adv;
  logic         accept;

  assign adv         = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || adv;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_step_r <= RAMP_STEP_RST;
    end else if (cfg_wr_en) begin
      ramp_step_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (accept) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_word_r.kind         <= in_ch.kind;
      in_word_r.left_target  <= in_ch.left_target;
      in_word_r.right_target <= in_ch.right_target;
      in_word_r.motor_select <= in_ch.motor_select;
      in_word_r.motor_speed  <= in_ch.motor_speed;
    end
  end

  tdr_step u_step (
    .st        (st_r),
    .word      (in_word_r),
    .ramp_step (ramp_step_r),
    .nxt       (st_nxt)
  );

  tdr_duty #(
    .DUTY_FULL (DUTY_FULL)
  ) u_duty (
    .cmd  (st_nxt.cmd),
    .duty (duty_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      duty_r      <= duty_nxt;
      out_left_r  <= st_nxt.left_level;
      out_right_r <= st_nxt.right_level;
    end
  end

  assign out_ch.valid           = out_vld_r;
  assign out_ch.fl_fwd_duty     = duty_r.fwd[0];
  assign out_ch.fl_rev_duty     = duty_r.rev[0];
  assign out_ch.rl_fwd_duty     = duty_r.fwd[1];
  assign out_ch.rl_rev_duty     = duty_r.rev[1];
  assign out_ch.fr_fwd_duty     = duty_r.fwd[2];
  assign out_ch.fr_rev_duty     = duty_r.rev[2];
  assign out_ch.rr_fwd_duty     = duty_r.fwd[3];
  assign out_ch.rr_rev_duty     = duty_r.rev[3];
  assign out_ch.left_level_now  = out_left_r;
  assign out_ch.right_level_now = out_right_r;

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    ($signed(st_r.left_level) >= $signed(PCT_MIN)) &&
    ($signed(st_r.left_level) <= $signed(PCT_MAX)) &&
    ($signed(st_r.right_level) >= $signed(PCT_MIN)) &&
    ($signed(st_r.right_level) <= $signed(PCT_MAX)))
    else $error("drive level out of range");

  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_word_r.kind == KIND_STOP) |=> (st_r == '0))
    else $error("stop word left state set");

  a_solo_one_motor: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && in_word_r.kind == KIND_SOLO) |=>
    ($countones({st_r.cmd[0] != '0, st_r.cmd[1] != '0,
                 st_r.cmd[2] != '0, st_r.cmd[3] != '0}) <= 1))
    else $error("override drives more than one motor");

  a_out_from_adv: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(adv))
    else $error("result word without a processed command");

endmodule
